// ===== rtl/core/erct_pkg.sv =====
// Edit range conflict table: shared constants, types and overlap functions.
// No dependencies; compile first.
package erct_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned POS_WIDTH   = 24;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned KIND_W      = 3;

  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [POS_WIDTH-1:0] pos_t;
  typedef logic [POS_WIDTH:0]   sum_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  localparam kind_t KIND_REPLACE = 3'd0;
  localparam kind_t KIND_MOVE    = 3'd1;
  localparam kind_t KIND_INSERT  = 3'd2;
  localparam kind_t KIND_REMOVE  = 3'd3;
  localparam kind_t KIND_FLIP    = 3'd4;
  localparam kind_t KIND_COPY    = 3'd5;
  localparam kind_t KIND_CLEAR   = 3'd6;

  typedef struct packed {
    kind_t kind;
    pos_t  p1;
    pos_t  l1;
    pos_t  p2;
    pos_t  l2;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Controller to datapath commands.
  typedef struct packed {
    logic  latch;
    logic  rd_en;
    addr_t rd_addr;
    logic  eval;
    logic  finish;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    cnt_t count;
    logic scan_op;
  } sts_t;

  // Range (a, la) against range or point (b, lb); sums carry one extra bit.
  function automatic logic ranges_meet(pos_t a, pos_t la, pos_t b, pos_t lb);
    sum_t ae;
    sum_t be;
    sum_t ax;
    sum_t bx;
    ae = {1'b0, a} + {1'b0, la};
    be = {1'b0, b} + {1'b0, lb};
    ax = {1'b0, a};
    bx = {1'b0, b};
    if (lb != '0) begin
      return (ax < be && ae >= be) || (a <= b && ae > bx) || (b < a && be > ae);
    end
    return (b > a) && (bx < ae);
  endfunction

  function automatic logic point_inside(pos_t p, pos_t a, pos_t la);
    sum_t ae;
    ae = {1'b0, a} + {1'b0, la};
    return (p > a) && ({1'b0, p} < ae);
  endfunction

  // Query range against one stored entry.
  function automatic logic entry_hit(pos_t a, pos_t la, entry_t e);
    logic hit;
    hit = 1'b0;
    unique case (e.kind)
      KIND_REPLACE, KIND_REMOVE: hit = ranges_meet(a, la, e.p1, e.l1);
      KIND_MOVE, KIND_COPY:      hit = ranges_meet(a, la, e.p1, e.l1)
                                       || point_inside(e.p2, a, la);
      KIND_INSERT:               hit = point_inside(e.p1, a, la);
      KIND_FLIP:                 hit = ranges_meet(a, la, e.p1, e.l1)
                                       || ranges_meet(a, la, e.p2, e.l2);
      default:                   hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== rtl/core/erct_if.sv =====
// Edit range conflict table: request and response channel interfaces.
// Depends on erct_pkg.
interface erct_req_if;
  import erct_pkg::*;
  logic  valid;
  logic  ready;
  kind_t req_type;
  pos_t  pos_a;
  pos_t  len_a;
  pos_t  pos_b;
  pos_t  len_b;
  modport source (output valid, req_type, pos_a, len_a, pos_b, len_b, input ready);
  modport sink   (input valid, req_type, pos_a, len_a, pos_b, len_b, output ready);
endinterface

interface erct_rsp_if;
  import erct_pkg::*;
  logic               valid;
  logic               ready;
  logic               ok;
  logic               conflict;
  logic               dropped;
  logic [COUNT_W-1:0] entry_count;
  modport source (output valid, ok, conflict, dropped, entry_count, input ready);
  modport sink   (input valid, ok, conflict, dropped, entry_count, output ready);
endinterface

// ===== rtl/core/edit_range_conflict_table_core.sv =====
// Edit range conflict table, top level: sequencer plus datapath.
// Depends on erct_pkg, erct_if, erct_ctrl, erct_dp (and erct_ram below it).
//
// Usage:
//   req_i carries one edit request per beat (kind, two ranges). rsp_o returns
//   exactly one result beat per request: ok (no error since last clear),
//   conflict, dropped and the entry count after the request.
//   Each table edit is compared against every stored entry, one entry per cycle
//   through the single read port of the entry table. An edit into an empty
//   table, a clear or an unused kind skips the scan.
//   One request is worked on at a time; req_i.ready is high only while idle,
//   so a new beat is taken only after the previous request has finished.
//   The result sits in an output register, so the next request is accepted
//   while the previous result still waits; if the receiver stalls, the block
//   finishes the next scan and then holds until the output register frees.
//   Reset empties the table (count zero, error clear); the entry memory
//   itself is not cleared, since only entries below the count are read.
module edit_range_conflict_table_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  erct_req_if.sink   req_i,
  erct_rsp_if.source rsp_o
);
  import erct_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: accept, scan the table, then commit and load the result.
  erct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: request hold, entry memory, overlap check, count and error.
  erct_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_i.req_type),
    .pos_a_i       (req_i.pos_a),
    .len_a_i       (req_i.len_a),
    .pos_b_i       (req_i.pos_b),
    .len_b_i       (req_i.len_b),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .ok_o          (rsp_o.ok),
    .conflict_o    (rsp_o.conflict),
    .dropped_o     (rsp_o.dropped),
    .entry_count_o (rsp_o.entry_count)
  );

endmodule

// ===== rtl/core/erct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module erct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/erct_ctrl.sv =====
// Edit range conflict table: sequencer for accept, table scan and finish.
// Depends on erct_pkg.
module erct_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  input  erct_pkg::sts_t sts_i,
  output erct_pkg::cmd_t cmd_o
);
  import erct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e state_q;
  cnt_t   idx_q;
  logic   rd_pend_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_addr = idx_q[ADDR_W-1:0];
    cmd_o.eval    = rd_pend_q;
    unique case (state_q)
      S_IDLE: cmd_o.latch  = req_valid_i;
      S_SCAN: cmd_o.rd_en  = sts_i.scan_op && (idx_q < sts_i.count);
      S_FIN:  cmd_o.finish = !out_valid_q || rsp_ready_i;
      default: cmd_o = '0;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_o.rd_en;
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            idx_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cmd_o.rd_en) begin
            idx_q <= idx_q + 1'b1;
          end else if (!rd_pend_q) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (cmd_o.finish) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Scan index never runs past the stored entries.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (idx_q <= sts_i.count))
    else $error("scan index beyond stored count");

  // Every issued read is followed by an evaluation of its data.
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |=> cmd_o.eval)
    else $error("read data not evaluated");

  // Finish only when the output slot can take the result.
  a_finish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || rsp_ready_i))
    else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/erct_dp.sv =====
// Edit range conflict table: request registers, entry table, overlap check,
// count and sticky error, result register. Depends on erct_pkg and erct_ram.
module erct_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  erct_pkg::kind_t             req_type_i,
  input  erct_pkg::pos_t              pos_a_i,
  input  erct_pkg::pos_t              len_a_i,
  input  erct_pkg::pos_t              pos_b_i,
  input  erct_pkg::pos_t              len_b_i,
  input  erct_pkg::cmd_t              cmd_i,
  output erct_pkg::sts_t              sts_o,
  output logic                        ok_o,
  output logic                        conflict_o,
  output logic                        dropped_o,
  output logic [erct_pkg::COUNT_W-1:0] entry_count_o
);
  import erct_pkg::*;

  kind_t  kind_q;
  pos_t   pa_q, la_q, pb_q, lb_q;
  logic   hit_q;
  logic   err_q;
  cnt_t   count_q;
  logic   ok_q, conflict_q, dropped_q;
  logic [COUNT_W-1:0] entry_count_q;

  logic   is_op, is_clear, is_insert, has_b, is_flip;
  pos_t   qa_len, qb_len;
  entry_t rd_entry, wr_entry;
  logic   scan_hit, self_hit, full, fin_hit, wr_en;
  logic   err_d;
  cnt_t   count_d;

  assign is_op     = (kind_q <= KIND_COPY);
  assign is_clear  = (kind_q == KIND_CLEAR);
  assign is_insert = (kind_q == KIND_INSERT);
  assign is_flip   = (kind_q == KIND_FLIP);
  assign has_b     = (kind_q == KIND_MOVE) || (kind_q == KIND_COPY) || is_flip;
  assign qa_len    = is_insert ? '0 : la_q;
  assign qb_len    = is_flip ? lb_q : '0;

  erct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rd_entry)
  );

  // One stored entry per beat against query range a, and range b too for move, copy and flip.
  assign scan_hit = entry_hit(pa_q, qa_len, rd_entry)
                    || (has_b && entry_hit(pb_q, qb_len, rd_entry));
  assign self_hit = has_b && ranges_meet(pa_q, la_q, pb_q, qb_len);
  assign full     = (count_q >= CNT_W'(TABLE_DEPTH));
  assign fin_hit  = is_op && (hit_q || self_hit);
  assign wr_en    = cmd_i.finish && is_op && !full;

  always_comb begin
    wr_entry.kind = kind_q;
    wr_entry.p1   = pa_q;
    wr_entry.l1   = qa_len;
    wr_entry.p2   = has_b ? pb_q : '0;
    wr_entry.l2   = qb_len;
  end

  always_comb begin
    err_d   = err_q;
    count_d = count_q;
    if (is_clear) begin
      err_d   = 1'b0;
      count_d = '0;
    end else if (is_op) begin
      err_d = err_q || fin_hit || full;
      if (!full) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  assign sts_o.count   = count_q;
  assign sts_o.scan_op = is_op;

  // Request and result payload: no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= req_type_i;
      pa_q   <= pos_a_i;
      la_q   <= len_a_i;
      pb_q   <= pos_b_i;
      lb_q   <= len_b_i;
    end
    if (cmd_i.finish) begin
      ok_q          <= !err_d;
      conflict_q    <= fin_hit;
      dropped_q     <= is_op && full;
      entry_count_q <= COUNT_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      err_q   <= 1'b0;
      count_q <= '0;
    end else begin
      if (cmd_i.latch) begin
        hit_q <= 1'b0;
      end else if (cmd_i.eval && scan_hit) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        err_q   <= err_d;
        count_q <= count_d;
      end
    end
  end

  assign ok_o          = ok_q;
  assign conflict_o    = conflict_q;
  assign dropped_o     = dropped_q;
  assign entry_count_o = entry_count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("stored count beyond table depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && is_clear) |=> (count_q == '0 && !err_q))
    else $error("clear left entries or error");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !full)
    else $error("write into full table");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for edit_range_conflict_table_core: a directed table, then random edit sequences.
// Each result is checked against a conflict-table predictor in this bench or a typed result.
// Depends on erct_pkg, erct_if and the core RTL.
module tb_top;
  import erct_pkg::*;

  // Kind 7 has no meaning; the block must leave its state alone.
  localparam kind_t       KIND_UNUSED     = 3'd7;
  localparam pos_t        POS_MAX         = '1;
  localparam int unsigned RANDOM_ITEMS    = 500;
  // Longest quiet stretch of a correct run is the receiver hold-off plus one full scan.
  localparam int unsigned RSP_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  // Allow a margin after the last result.
  localparam int unsigned TAIL_CYCLES     = 80;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    kind_t kind;
    pos_t  pos_a;
    pos_t  len_a;
    pos_t  pos_b;
    pos_t  len_b;
  } edit_req_t;

  typedef struct packed {
    logic               ok;
    logic               conflict;
    logic               dropped;
    logic [COUNT_W-1:0] entry_count;
  } verdict_t;

  // One row of the directed table; reps > 1 repeats the request with pos_a stepped by stride.
  typedef struct {
    edit_req_t   req;
    int unsigned reps;
    pos_t        stride;
    bit          typed;
    verdict_t    want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  erct_req_if req_if();
  erct_rsp_if rsp_if();

  edit_range_conflict_table_core uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the conflict table.
  entry_t      ledger [TABLE_DEPTH];
  int unsigned ledger_len;
  bit          ledger_err;

  verdict_t    verdict_q[$];
  stim_row_t   plan[$];

  int unsigned req_gap_pct;
  int unsigned rsp_stall_pct;
  bit          rsp_hold_pending;
  int unsigned idle_cycles;

  int unsigned n_sent;
  int unsigned n_clears;
  int unsigned n_ignored;
  int unsigned n_checked;
  int unsigned n_conflicts;
  int unsigned n_drops;
  int unsigned n_bad;

  // Range (qs, ql) against range (es, el), or against the point es when el is zero.
  // End points are formed one bit wider so they never wrap.
  function automatic bit spans_touch(pos_t qs, pos_t ql, pos_t es, pos_t el);
    sum_t qa;
    sum_t qz;
    sum_t ea;
    sum_t ez;
    qa = {1'b0, qs};
    qz = qa + ql;
    ea = {1'b0, es};
    ez = ea + el;
    // A point only counts when it lies strictly inside the query range.
    if (el == '0) return (ea > qa) && (ea < qz);
    return (qa < ez && qz >= ez) || (qa <= ea && qz > ea) || (ea < qa && ez > qz);
  endfunction

  // Check a query range against every stored entry. Unused parts are stored as zero, and a
  // zero point at position zero never lies strictly inside anything, so both parts of every
  // entry can be checked the same way: inserts and move/copy targets fall to the point rule.
  function automatic bit ledger_hits(pos_t qs, pos_t ql);
    bit hit;
    hit = 1'b0;
    for (int unsigned i = 0; i < ledger_len; i++) begin
      hit |= spans_touch(qs, ql, ledger[i].p1, ledger[i].l1)
          || spans_touch(qs, ql, ledger[i].p2, ledger[i].l2);
    end
    return hit;
  endfunction

  // Advance the shadow table by one request and return the result it must produce.
  function automatic verdict_t apply_edit(edit_req_t r);
    verdict_t v;
    entry_t   e;
    bit       hit;
    v      = '0;
    hit    = 1'b0;
    e.kind = r.kind;
    e.p1   = r.pos_a;
    e.l1   = r.len_a;
    e.p2   = '0;
    e.l2   = '0;
    case (r.kind)
      KIND_CLEAR: begin
        ledger_len = 0;
        ledger_err = 1'b0;
      end
      KIND_REPLACE, KIND_REMOVE: hit = ledger_hits(r.pos_a, r.len_a);
      KIND_INSERT: begin
        e.l1 = '0;
        hit  = ledger_hits(r.pos_a, '0);
      end
      KIND_MOVE, KIND_COPY: begin
        e.p2 = r.pos_b;
        hit  = ledger_hits(r.pos_a, r.len_a) || ledger_hits(r.pos_b, '0)
            || spans_touch(r.pos_a, r.len_a, r.pos_b, '0);
      end
      KIND_FLIP: begin
        e.p2 = r.pos_b;
        e.l2 = r.len_b;
        hit  = ledger_hits(r.pos_a, r.len_a) || ledger_hits(r.pos_b, r.len_b)
            || spans_touch(r.pos_a, r.len_a, r.pos_b, r.len_b);
      end
      default: ;
    endcase
    if (r.kind <= KIND_COPY) begin
      if (hit) ledger_err = 1'b1;
      // Full table: drop the edit but still report the conflict check.
      if (ledger_len >= TABLE_DEPTH) begin
        v.dropped  = 1'b1;
        ledger_err = 1'b1;
      end else begin
        ledger[ledger_len] = e;
        ledger_len++;
      end
    end
    v.ok          = !ledger_err;
    v.conflict    = hit;
    v.entry_count = COUNT_W'(ledger_len);
    return v;
  endfunction

  function automatic void add_row(edit_req_t req, int unsigned reps, pos_t stride, bit typed,
                                  verdict_t want);
    stim_row_t row;
    row.req    = req;
    row.reps   = reps;
    row.stride = stride;
    row.typed  = typed;
    row.want   = want;
    plan.push_back(row);
  endfunction

  // Lengths: mostly short or zero, some medium, some anywhere in the field.
  function automatic pos_t pick_len();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return '0;
    if (roll < 8) return pos_t'($urandom_range(1, 40));
    if (roll == 8) return pos_t'($urandom_range(41, 4095));
    return pos_t'($urandom);
  endfunction

  task automatic note_bad(string what, verdict_t want, verdict_t got);
    n_bad++;
    if (n_bad <= MAX_REPORTS) begin
      $display("%0t: %s: want ok=%0b conflict=%0b dropped=%0b count=%0d,",
               $time, what, want.ok, want.conflict, want.dropped, want.entry_count);
      $display("    got ok=%0b conflict=%0b dropped=%0b count=%0d",
               got.ok, got.conflict, got.dropped, got.entry_count);
    end
  endtask

  // Offer one request beat, hold it until accepted, then predict its result.
  // Leave valid high when no gap follows, so back-to-back beats need no second update.
  task automatic send_edit(edit_req_t r, bit typed, verdict_t want);
    verdict_t guess;
    req_if.valid    <= 1'b1;
    req_if.req_type <= r.kind;
    req_if.pos_a    <= r.pos_a;
    req_if.len_a    <= r.len_a;
    req_if.pos_b    <= r.pos_b;
    req_if.len_b    <= r.len_b;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    guess = apply_edit(r);
    verdict_q.push_back(typed ? want : guess);
    n_sent++;
    if (r.kind == KIND_CLEAR) n_clears++;
    if (r.kind == KIND_UNUSED) n_ignored++;
    if ($urandom_range(0, 99) < req_gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Random part: sequences that mostly open with a clear and then pile edits around one base,
  // so stored ranges sit close together and conflicts are common. Some sequences run past the
  // table size to reach the full-table drop; a few beats are noise or break the sequence.
  task automatic run_random();
    int unsigned done_items;
    int unsigned seq_len;
    int unsigned roll;
    bit          hold_done;
    bit          pause_done;
    pos_t        base;
    edit_req_t   r;
    done_items = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (done_items < RANDOM_ITEMS) begin
      // Pick the idling for this stretch; the last part runs flat out.
      if (done_items + 80 >= RANDOM_ITEMS || $urandom_range(0, 3) == 0) begin
        req_gap_pct   = 0;
        rsp_stall_pct = 0;
      end else begin
        req_gap_pct   = $urandom_range(5, 40);
        rsp_stall_pct = $urandom_range(5, 40);
      end
      roll    = $urandom_range(0, 9);
      seq_len = (roll < 6) ? $urandom_range(1, 24) :
                (roll < 9) ? $urandom_range(25, 50) : $urandom_range(60, 72);
      // Once: stall the receiver for a long stretch while requests keep coming.
      if (!hold_done && done_items >= 150) begin
        hold_done        = 1'b1;
        rsp_hold_pending = 1'b1;
        seq_len          = 40;
      end
      // Once: let the sender go quiet until the block has returned everything.
      if (!pause_done && done_items >= 350) begin
        pause_done = 1'b1;
        wait_drained();
      end
      roll = $urandom_range(0, 3);
      base = (roll < 2)  ? pos_t'($urandom_range(0, 2047)) :
             (roll == 2) ? POS_MAX - pos_t'($urandom_range(0, 2047)) : pos_t'($urandom);
      if ($urandom_range(0, 9) != 0) begin
        r.kind  = KIND_CLEAR;
        r.pos_a = pos_t'($urandom);
        r.len_a = pos_t'($urandom);
        r.pos_b = pos_t'($urandom);
        r.len_b = pos_t'($urandom);
        send_edit(r, 1'b0, '0);
        done_items++;
      end
      repeat (seq_len) begin
        roll    = $urandom_range(0, 99);
        r.kind  = kind_t'($urandom_range(KIND_REPLACE, KIND_COPY));
        r.pos_a = base + pos_t'($urandom_range(0, 255));
        r.len_a = pick_len();
        r.pos_b = base + pos_t'($urandom_range(0, 255));
        r.len_b = pick_len();
        if (roll < 3) begin
          r.kind = KIND_UNUSED;
        end else if (roll < 6) begin
          r.kind = KIND_CLEAR;
        end else if (roll < 12) begin
          r.pos_a = pos_t'($urandom);
          r.len_a = pos_t'($urandom);
          r.pos_b = pos_t'($urandom);
          r.len_b = pos_t'($urandom);
        end
        send_edit(r, 1'b0, '0);
        if (r.kind != KIND_UNUSED) done_items++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall bursts, plus one long hold-off counted here on request.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_pending) begin
        rsp_hold_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        rsp_if.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin : rsp_check
    verdict_t want;
    verdict_t got;
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.ok          = rsp_if.ok;
      got.conflict    = rsp_if.conflict;
      got.dropped     = rsp_if.dropped;
      got.entry_count = rsp_if.entry_count;
      if (verdict_q.size() == 0) begin
        note_bad("result with nothing pending", '0, got);
      end else begin
        want = verdict_q.pop_front();
        n_checked++;
        if (want.conflict) n_conflicts++;
        if (want.dropped) n_drops++;
        if (got.ok !== want.ok || got.conflict !== want.conflict ||
            got.dropped !== want.dropped || got.entry_count !== want.entry_count) begin
          note_bad("bad result", want, got);
        end
      end
    end
  end

  // Count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
    $display("timeout after %0d cycles without a beat", WATCHDOG_LIMIT);
    $display("edit_range_conflict_table_core: mismatch");
    $finish;
  end

  initial begin : main
    edit_req_t r;
    idle_cycles      = 0;
    rsp_hold_pending = 1'b0;
    ledger_len       = 0;
    ledger_err       = 1'b0;
    req_gap_pct      = 15;
    rsp_stall_pct    = 15;
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= KIND_REPLACE;
    req_if.pos_a    <= '0;
    req_if.len_a    <= '0;
    req_if.pos_b    <= '0;
    req_if.len_b    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. Typed results only where they are obvious: an empty table after reset or clear,
    // extreme fields, a clear, an unused kind, a self-overlapping move and a full table.
    add_row({KIND_REPLACE, 24'd0, 24'd0, 24'd0, 24'd0}, 1, '0, 1'b1,
            {1'b1, 1'b0, 1'b0, 7'd1});
    add_row({KIND_INSERT, POS_MAX, POS_MAX, POS_MAX, POS_MAX}, 1, '0, 1'b1,
            {1'b1, 1'b0, 1'b0, 7'd2});
    // Top-of-field ranges whose ends need the carry bit.
    add_row({KIND_REMOVE, POS_MAX, POS_MAX, 24'd0, 24'd0}, 1, '0, 1'b0, '0);
    add_row({KIND_FLIP, 24'd0, POS_MAX, POS_MAX, POS_MAX}, 1, '0, 1'b0, '0);
    add_row({KIND_UNUSED, POS_MAX, POS_MAX, POS_MAX, POS_MAX}, 1, '0, 1'b0, '0);
    add_row({KIND_CLEAR, POS_MAX, POS_MAX, POS_MAX, POS_MAX}, 1, '0, 1'b1,
            {1'b1, 1'b0, 1'b0, 7'd0});
    add_row({KIND_UNUSED, 24'd0, 24'd0, 24'd0, 24'd0}, 1, '0, 1'b1,
            {1'b1, 1'b0, 1'b0, 7'd0});
    // Nested range, and a point on a range edge rather than strictly inside.
    add_row({KIND_REPLACE, 24'd100, 24'd20, 24'd0, 24'd0}, 1, '0, 1'b1,
            {1'b1, 1'b0, 1'b0, 7'd1});
    add_row({KIND_REMOVE, 24'd110, 24'd5, 24'd0, 24'd0}, 1, '0, 1'b0, '0);
    add_row({KIND_INSERT, 24'd100, 24'd7, 24'd0, 24'd0}, 1, '0, 1'b0, '0);
    add_row({KIND_CLEAR, 24'd0, 24'd0, 24'd0, 24'd0}, 1, '0, 1'b1,
            {1'b1, 1'b0, 1'b0, 7'd0});
    // Move whose target lies inside its own source.
    add_row({KIND_MOVE, 24'd50, 24'd10, 24'd55, 24'd0}, 1, '0, 1'b1,
            {1'b0, 1'b1, 1'b0, 7'd1});
    add_row({KIND_COPY, 24'd200, 24'd10, 24'd210, 24'd0}, 1, '0, 1'b0, '0);
    add_row({KIND_INSERT, 24'd205, 24'd0, 24'd0, 24'd0}, 1, '0, 1'b0, '0);
    // Flip with overlapping halves, then with adjacent halves, then a range over both.
    add_row({KIND_FLIP, 24'd300, 24'd10, 24'd305, 24'd10}, 1, '0, 1'b0, '0);
    add_row({KIND_FLIP, 24'd400, 24'd5, 24'd405, 24'd5}, 1, '0, 1'b0, '0);
    add_row({KIND_REPLACE, 24'd395, 24'd20, 24'd0, 24'd0}, 1, '0, 1'b0, '0);
    add_row({KIND_CLEAR, 24'd0, 24'd0, 24'd0, 24'd0}, 1, '0, 1'b1,
            {1'b1, 1'b0, 1'b0, 7'd0});
    // Fill the table with disjoint replaces, then overflow it.
    add_row({KIND_REPLACE, 24'd1000, 24'd4, 24'd0, 24'd0}, TABLE_DEPTH, 24'd10, 1'b0, '0);
    add_row({KIND_REMOVE, 24'd5000, 24'd1, 24'd0, 24'd0}, 1, '0, 1'b1,
            {1'b0, 1'b0, 1'b1, 7'd64});
    // Full table: the conflict check still runs.
    add_row({KIND_INSERT, 24'd1002, 24'd0, 24'd0, 24'd0}, 1, '0, 1'b0, '0);
    add_row({KIND_CLEAR, 24'd0, 24'd0, 24'd0, 24'd0}, 1, '0, 1'b1,
            {1'b1, 1'b0, 1'b0, 7'd0});

    foreach (plan[i]) begin
      for (int unsigned k = 0; k < plan[i].reps; k++) begin
        r       = plan[i].req;
        r.pos_a = plan[i].req.pos_a + pos_t'(k) * plan[i].stride;
        send_edit(r, plan[i].typed, plan[i].want);
      end
    end
    wait_drained();

    run_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("drove %0d requests (%0d clears, %0d unused kinds), checked %0d results",
             n_sent, n_clears, n_ignored, n_checked);
    $display("saw %0d conflicts and %0d full-table drops; %0d bad results",
             n_conflicts, n_drops, n_bad);
    if (n_bad == 0 && verdict_q.size() == 0) begin
      $display("edit_range_conflict_table_core: match");
    end else begin
      $display("edit_range_conflict_table_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/erct_pkg.sv
rtl/core/erct_if.sv
rtl/core/erct_ram.sv
rtl/core/erct_ctrl.sv
rtl/core/erct_dp.sv
rtl/core/edit_range_conflict_table_core.sv
dv/tb_top.sv
